// ===== rtl/spectral_angle_mapper_assert.svh =====
// Assertion macros for the spectral angle mapper
`ifndef SPECTRAL_ANGLE_MAPPER_ASSERT_SVH
`define SPECTRAL_ANGLE_MAPPER_ASSERT_SVH

// Consequent checked in the same cycle
`define SAM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spectral angle mapper check failed");

// Consequent checked in the next cycle
`define SAM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spectral angle mapper check failed");

`endif

// ===== rtl/sam_pkg.sv =====
`default_nettype none
package sam_pkg;

    localparam int SAMPLE_BITS         = 16;
    localparam int BAND_BITS           = 8;
    localparam int ANGLE_BITS          = 16;
    localparam int DOT_BITS            = 40;
    localparam int ENERGY_BITS         = 39;
    localparam int CORDIC_STEPS        = 24;
    localparam int MAX_BANDS_DEF       = 256;
    localparam int ANGLE_FRAC_BITS_DEF = 8;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_PIXEL = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic signed [31:0] DEG90_Q20  = 32'sd94371840;
    localparam logic signed [31:0] DEG180_Q20 = 32'sd188743680;

    typedef struct packed {
        logic busy;
        logic done;
    } sam_ang_status_t;

    function automatic logic [25:0] cordic_atan(input logic [4:0] step);
        logic [25:0] r;
        case (step)
            5'd0:    r = 26'd47185920;
            5'd1:    r = 26'd27855475;
            5'd2:    r = 26'd14718068;
            5'd3:    r = 26'd7471121;
            5'd4:    r = 26'd3750058;
            5'd5:    r = 26'd1876857;
            5'd6:    r = 26'd938658;
            5'd7:    r = 26'd469357;
            5'd8:    r = 26'd234682;
            5'd9:    r = 26'd117342;
            5'd10:   r = 26'd58671;
            5'd11:   r = 26'd29335;
            5'd12:   r = 26'd14668;
            5'd13:   r = 26'd7334;
            5'd14:   r = 26'd3667;
            5'd15:   r = 26'd1833;
            5'd16:   r = 26'd917;
            5'd17:   r = 26'd458;
            5'd18:   r = 26'd229;
            5'd19:   r = 26'd115;
            5'd20:   r = 26'd57;
            5'd21:   r = 26'd29;
            5'd22:   r = 26'd14;
            5'd23:   r = 26'd7;
            default: r = 26'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sam_in_if.sv =====
`default_nettype none
interface sam_in_if
    import sam_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [1:0]             action;
    logic [BAND_BITS-1:0]   band;
    logic [SAMPLE_BITS-1:0] sample_value;
    logic                   pixel_in_mask;
    logic                   last_sample;

    modport source (output valid, action, band, sample_value, pixel_in_mask, last_sample,
                    input ready);
    modport sink   (input valid, action, band, sample_value, pixel_in_mask, last_sample,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/sam_out_if.sv =====
`default_nettype none
interface sam_out_if
    import sam_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [ANGLE_BITS-1:0] angle;
    logic                  no_angle;

    modport source (output valid, angle, no_angle, input ready);
    modport sink   (input valid, angle, no_angle, output ready);
endinterface
`default_nettype wire

// ===== rtl/sam_angle.sv =====
`default_nettype none
module sam_angle
    import sam_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [DOT_BITS-1:0]     dot,
    input  wire logic [ENERGY_BITS-1:0]  pe,
    input  wire logic [ENERGY_BITS-1:0]  re,
    output sam_ang_status_t              status,
    output logic [ANGLE_BITS-1:0]        q
);

    typedef enum logic [2:0] {
        A_IDLE, A_MUL_P, A_MUL_D, A_DIFF, A_SQRT, A_NORM, A_CORDIC, A_ROUND
    } ang_state_t;

    localparam logic signed [31:0] HALF_LSB = 32'sd1 <<< (19 - ANGLE_FRAC_BITS);

    ang_state_t          state_reg;
    logic                done_reg;
    logic [5:0]          cnt_reg;
    logic                neg_reg;
    logic [39:0]         mag_reg;
    logic [79:0]         acc_reg;
    logic [39:0]         mplier_reg;
    logic [39:0]         mcand_reg;
    logic [79:0]         p_reg;
    logic [79:0]         d_reg;
    logic [79:0]         rad_reg;
    logic [42:0]         rem_reg;
    logic [39:0]         root_reg;
    logic [39:0]         x_reg;
    logic [39:0]         y_reg;
    logic signed [33:0]  cx_reg;
    logic signed [33:0]  cy_reg;
    logic signed [31:0]  z_reg;
    logic [4:0]          i_reg;
    logic [ANGLE_BITS-1:0] q_reg;

    logic [79:0]         sum_next;
    logic [42:0]         rem_sh;
    logic [42:0]         trial;
    logic [39:0]         m;
    logic signed [33:0]  sx;
    logic signed [33:0]  sy;
    logic signed [31:0]  atan_s;
    logic signed [31:0]  zc;
    logic signed [31:0]  qsum;
    logic [39:0]         mag_in;

    always_comb
    begin
        sum_next = {acc_reg[78:0], 1'b0} + (mplier_reg[39] ? {40'd0, mcand_reg} : 80'd0);
        rem_sh   = {rem_reg[40:0], rad_reg[79:78]};
        trial    = {1'b0, root_reg, 2'b01};
        m        = x_reg | y_reg;
        sx       = cx_reg >>> i_reg;
        sy       = cy_reg >>> i_reg;
        atan_s   = signed'({6'd0, cordic_atan(i_reg)});
        mag_in   = dot[DOT_BITS-1] ? (~dot + 40'd1) : dot;
        zc       = z_reg;
        if (z_reg < 32'sd0)
        begin
            zc = 32'sd0;
        end
        else if (z_reg > DEG90_Q20)
        begin
            zc = DEG90_Q20;
        end
        if (neg_reg)
        begin
            zc = DEG180_Q20 - zc;
        end
        qsum = (zc + HALF_LSB) >>> (20 - ANGLE_FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                A_IDLE:
                begin
                    if (start)
                    begin
                        neg_reg    <= dot[DOT_BITS-1];
                        mag_reg    <= mag_in;
                        acc_reg    <= '0;
                        mplier_reg <= {1'b0, pe};
                        mcand_reg  <= {1'b0, re};
                        cnt_reg    <= '0;
                        state_reg  <= A_MUL_P;
                    end
                end
                A_MUL_P:
                begin
                    acc_reg    <= sum_next;
                    mplier_reg <= {mplier_reg[38:0], 1'b0};
                    cnt_reg    <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd39)
                    begin
                        p_reg      <= sum_next;
                        acc_reg    <= '0;
                        mplier_reg <= mag_reg;
                        mcand_reg  <= mag_reg;
                        cnt_reg    <= '0;
                        state_reg  <= A_MUL_D;
                    end
                end
                A_MUL_D:
                begin
                    acc_reg    <= sum_next;
                    mplier_reg <= {mplier_reg[38:0], 1'b0};
                    cnt_reg    <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd39)
                    begin
                        d_reg     <= sum_next;
                        state_reg <= A_DIFF;
                    end
                end
                A_DIFF:
                begin
                    rad_reg   <= (p_reg > d_reg) ? (p_reg - d_reg) : 80'd0;
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= A_SQRT;
                end
                A_SQRT:
                begin
                    rad_reg <= {rad_reg[77:0], 2'b00};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (rem_sh >= trial)
                    begin
                        rem_reg  <= rem_sh - trial;
                        root_reg <= {root_reg[38:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[38:0], 1'b0};
                    end
                    if (cnt_reg == 6'd39)
                    begin
                        x_reg     <= mag_reg;
                        y_reg     <= {root_reg[38:0], (rem_sh >= trial)};
                        state_reg <= A_NORM;
                    end
                end
                A_NORM:
                begin
                    if (|m[39:30])
                    begin
                        x_reg <= {1'b0, x_reg[39:1]};
                        y_reg <= {1'b0, y_reg[39:1]};
                    end
                    else if ((m != 40'd0) && !m[29])
                    begin
                        x_reg <= {x_reg[38:0], 1'b0};
                        y_reg <= {y_reg[38:0], 1'b0};
                    end
                    else
                    begin
                        cx_reg    <= signed'({4'd0, x_reg[29:0]});
                        cy_reg    <= signed'({4'd0, y_reg[29:0]});
                        z_reg     <= '0;
                        i_reg     <= '0;
                        state_reg <= A_CORDIC;
                    end
                end
                A_CORDIC:
                begin
                    if (!cy_reg[33])
                    begin
                        cx_reg <= cx_reg + sy;
                        cy_reg <= cy_reg - sx;
                        z_reg  <= z_reg + atan_s;
                    end
                    else
                    begin
                        cx_reg <= cx_reg - sy;
                        cy_reg <= cy_reg + sx;
                        z_reg  <= z_reg - atan_s;
                    end
                    i_reg <= i_reg + 5'd1;
                    if (i_reg == 5'(CORDIC_STEPS - 1))
                    begin
                        state_reg <= A_ROUND;
                    end
                end
                A_ROUND:
                begin
                    q_reg     <= qsum[ANGLE_BITS-1:0];
                    done_reg  <= 1'b1;
                    state_reg <= A_IDLE;
                end
                default:
                begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    assign status.busy = (state_reg != A_IDLE);
    assign status.done = done_reg;
    assign q           = q_reg;

endmodule
`default_nettype wire

// ===== rtl/spectral_angle_mapper.sv =====
// Channel   Direction  Payload
// samples   in         action, band, sample_value, pixel_in_mask, last_sample
// result    out        angle, no_angle
//
// Reference load: fetch, old square off if marked, new square on. Marked pixel sample:
// fetch, product to dot sum, square to pixel energy, finish; all 16x16 products.
// Clear, unknown action or load out of range: fetch only. Other pixel sample: fetch,
// finish. Last sample with an angle: bit-serial multiplier (2 x 40), digit-by-digit
// square root (40), up to 29 normalising shifts, 24-step CORDIC; else straight to emit.
// Reset clears the band marks and sums at once; a result still waiting holds the
// next result in its emit step, and no request is taken meanwhile.
`default_nettype none
`include "spectral_angle_mapper_assert.svh"
module spectral_angle_mapper
    import sam_pkg::*;
#(
    parameter int MAX_BANDS       = MAX_BANDS_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    sam_in_if.sink    samples,
    sam_out_if.source result
);

    localparam int DEPTH = (MAX_BANDS < (1 << BAND_BITS)) ? MAX_BANDS : (1 << BAND_BITS);
    localparam int AW    = $clog2(DEPTH);
    localparam logic [ANGLE_BITS-1:0] NO_ANGLE = ANGLE_BITS'(181 << ANGLE_FRAC_BITS);

    typedef enum logic [3:0] {
        T_IDLE, T_FETCH, T_MUL0, T_ACC0, T_MUL1, T_ACC1, T_FIN, T_WAIT, T_EMIT
    } top_state_t;

    top_state_t                    state_reg;
    logic [1:0]                    act_reg;
    logic                          ok_reg;
    logic [AW-1:0]                 addr_reg;
    logic signed [SAMPLE_BITS-1:0] v_reg;
    logic                          mask_reg;
    logic                          last_reg;
    logic signed [SAMPLE_BITS-1:0] rv_reg;
    logic                          used_reg;
    logic signed [2*SAMPLE_BITS-1:0] prod_reg;
    logic [DEPTH-1:0]              band_used_reg;
    logic [ENERGY_BITS-1:0]        re_reg;
    logic [ENERGY_BITS-1:0]        pe_reg;
    logic [DOT_BITS-1:0]           dot_reg;
    logic                          out_valid_reg;
    logic [ANGLE_BITS-1:0]         angle_reg;
    logic                          no_angle_reg;
    logic [ANGLE_BITS-1:0]         ang_pend_reg;
    logic                          none_pend_reg;
    logic                          start_reg;
    logic [ANGLE_BITS-1:0]         ang_q;
    sam_ang_status_t               ang_status;

    logic signed [SAMPLE_BITS-1:0] rv_mem [DEPTH];

    logic signed [SAMPLE_BITS-1:0] op_b;
    logic [ENERGY_BITS-1:0]        prod_e;
    logic [DOT_BITS-1:0]           prod_d;
    logic                          band_ok;
    logic                          emit_fire;

    always_comb
    begin
        op_b      = (state_reg == T_MUL1) ? v_reg : rv_reg;
        prod_e    = ENERGY_BITS'(unsigned'(prod_reg));
        prod_d    = DOT_BITS'(prod_reg);
        band_ok   = (32'(samples.band) < MAX_BANDS);
        emit_fire = (state_reg == T_EMIT) && (!out_valid_reg || result.ready);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == T_FETCH)
        begin
            rv_reg <= rv_mem[addr_reg];
        end
        if ((state_reg == T_ACC1) && (act_reg == ACT_LOAD))
        begin
            rv_mem[addr_reg] <= v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            band_used_reg <= '0;
            re_reg        <= '0;
            pe_reg        <= '0;
            dot_reg       <= '0;
            out_valid_reg <= 1'b0;
            start_reg     <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                T_IDLE:
                begin
                    if (samples.valid)
                    begin
                        act_reg   <= samples.action;
                        ok_reg    <= band_ok;
                        addr_reg  <= samples.band[AW-1:0];
                        v_reg     <= signed'(samples.sample_value);
                        mask_reg  <= samples.pixel_in_mask;
                        last_reg  <= samples.last_sample;
                        state_reg <= T_FETCH;
                    end
                end
                T_FETCH:
                begin
                    used_reg <= ok_reg && band_used_reg[addr_reg];
                    case (act_reg)
                        ACT_LOAD:  state_reg <= ok_reg ? T_MUL0 : T_IDLE;
                        ACT_PIXEL: state_reg <= (ok_reg && band_used_reg[addr_reg]) ?
                                                T_MUL0 : T_FIN;
                        ACT_CLEAR:
                        begin
                            band_used_reg <= '0;
                            re_reg        <= '0;
                            state_reg     <= T_IDLE;
                        end
                        default:   state_reg <= T_IDLE;
                    endcase
                end
                T_MUL0:
                begin
                    prod_reg  <= ((act_reg == ACT_LOAD) ? rv_reg : v_reg) * op_b;
                    state_reg <= T_ACC0;
                end
                T_ACC0:
                begin
                    if (act_reg == ACT_LOAD)
                    begin
                        if (used_reg)
                        begin
                            re_reg <= re_reg - prod_e;
                        end
                    end
                    else
                    begin
                        dot_reg <= dot_reg + prod_d;
                    end
                    state_reg <= T_MUL1;
                end
                T_MUL1:
                begin
                    prod_reg  <= v_reg * op_b;
                    state_reg <= T_ACC1;
                end
                T_ACC1:
                begin
                    if (act_reg == ACT_LOAD)
                    begin
                        re_reg                  <= re_reg + prod_e;
                        band_used_reg[addr_reg] <= 1'b1;
                        state_reg               <= T_IDLE;
                    end
                    else
                    begin
                        pe_reg    <= pe_reg + prod_e;
                        state_reg <= T_FIN;
                    end
                end
                T_FIN:
                begin
                    if (!last_reg)
                    begin
                        state_reg <= T_IDLE;
                    end
                    else if (!mask_reg || (pe_reg == '0) || (re_reg == '0))
                    begin
                        ang_pend_reg  <= NO_ANGLE;
                        none_pend_reg <= 1'b1;
                        state_reg     <= T_EMIT;
                    end
                    else
                    begin
                        start_reg <= 1'b1;
                        state_reg <= T_WAIT;
                    end
                end
                T_WAIT:
                begin
                    if (ang_status.done)
                    begin
                        ang_pend_reg  <= ang_q;
                        none_pend_reg <= 1'b0;
                        state_reg     <= T_EMIT;
                    end
                end
                T_EMIT:
                begin
                    if (emit_fire)
                    begin
                        angle_reg    <= ang_pend_reg;
                        no_angle_reg <= none_pend_reg;
                        dot_reg      <= '0;
                        pe_reg       <= '0;
                        state_reg    <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    sam_angle #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_angle (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_reg),
        .dot    (dot_reg),
        .pe     (pe_reg),
        .re     (re_reg),
        .status (ang_status),
        .q      (ang_q)
    );

    assign samples.ready   = (state_reg == T_IDLE);
    assign result.valid    = out_valid_reg;
    assign result.angle    = angle_reg;
    assign result.no_angle = no_angle_reg;

    `SAM_ASSERT_NEXT(a_busy_after_request, samples.valid && samples.ready, !samples.ready)
    `SAM_ASSERT_NOW(a_no_angle_code, result.valid && result.no_angle, result.angle == NO_ANGLE)
    `SAM_ASSERT_NOW(a_start_when_idle, start_reg, !ang_status.busy)
    `SAM_ASSERT_NOW(a_ready_unit_idle, samples.ready, !ang_status.busy)

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none
module tb;
    import sam_pkg::*;

    localparam int QUIET_LIMIT = 20000;
    localparam int RAND_ITEMS  = 330;
    localparam logic [1:0] ACT_BAD = 2'd3;

    typedef struct {
        logic [1:0]             action;
        logic [BAND_BITS-1:0]   band;
        logic [SAMPLE_BITS-1:0] value;
        logic                   in_mask;
        logic                   last;
        bit                     pause;
    } band_req_t;

    typedef struct {
        logic [ANGLE_BITS-1:0] angle;
        logic                  no_angle;
    } angle_t;

    localparam longint ATAN_Q20 [CORDIC_STEPS] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    logic clk;
    logic rst_n;

    sam_in_if  smp();
    sam_out_if res();

    spectral_angle_mapper DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (smp),
        .result  (res)
    );

    band_req_t pending[$];
    angle_t    angle_due[$];
    band_req_t cur;

    logic [SAMPLE_BITS-1:0] spec_val [MAX_BANDS_DEF];
    bit                     spec_mark [MAX_BANDS_DEF];
    logic [ENERGY_BITS-1:0] spec_energy;
    logic [DOT_BITS-1:0]    dot_sum;
    logic [ENERGY_BITS-1:0] pix_energy;

    int  errors, n_in, n_out, n_none, quiet, total;
    int  send_idle, recv_idle;

    logic [SAMPLE_BITS-1:0] g_val [MAX_BANDS_DEF];
    int  g_bands[$];
    int  n_gen;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic logic [ANGLE_BITS-1:0] sam_angle(logic [DOT_BITS-1:0] d,
                                                      logic [ENERGY_BITS-1:0] pe,
                                                      logic [ENERGY_BITS-1:0] re);
        bit                  neg;
        logic [DOT_BITS-1:0] mag;
        logic [127:0]        p, dd, rem, c2;
        logic [63:0]         x, y, m, c;
        longint              cx, cy, z, nx, q;
        neg = d[DOT_BITS-1];
        mag = neg ? -d : d;
        p   = 128'(pe) * 128'(re);
        dd  = 128'(mag) * 128'(mag);
        y   = '0;
        if (p > dd)
        begin
            rem = p - dd;
            for (int i = 39; i >= 0; i--)
            begin
                c  = y | (64'd1 << i);
                c2 = 128'(c) * 128'(c);
                if (c2 <= rem)
                    y = c;
            end
        end
        x = 64'(mag);
        m = x | y;
        while (m >= (64'd1 << 30))
        begin
            x = x >> 1; y = y >> 1; m = m >> 1;
        end
        while (m != 0 && m < (64'd1 << 29))
        begin
            x = x << 1; y = y << 1; m = m << 1;
        end
        cx = longint'(x);
        cy = longint'(y);
        z  = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (cy >= 0)
            begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                z  = z + ATAN_Q20[i];
            end
            else
            begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                z  = z - ATAN_Q20[i];
            end
            cx = nx;
        end
        if (z < 0)
            z = 0;
        if (z > longint'(DEG90_Q20))
            z = longint'(DEG90_Q20);
        if (neg)
            z = longint'(DEG180_Q20) - z;
        q = (z + 2048) >>> 12;
        return q[ANGLE_BITS-1:0];
    endfunction

    task automatic sam_predict(band_req_t it);
        longint v, o;
        angle_t a;
        v = longint'($signed(it.value));
        if (it.action == ACT_LOAD)
        begin
            if (spec_mark[it.band])
            begin
                o = longint'($signed(spec_val[it.band]));
                spec_energy = spec_energy - ENERGY_BITS'(o * o);
            end
            spec_val[it.band]  = it.value;
            spec_mark[it.band] = 1'b1;
            spec_energy = spec_energy + ENERGY_BITS'(v * v);
        end
        else if (it.action == ACT_CLEAR)
        begin
            foreach (spec_mark[i])
                spec_mark[i] = 1'b0;
            spec_energy = '0;
        end
        else if (it.action == ACT_PIXEL)
        begin
            if (spec_mark[it.band])
            begin
                o = longint'($signed(spec_val[it.band]));
                dot_sum    = dot_sum + DOT_BITS'(v * o);
                pix_energy = pix_energy + ENERGY_BITS'(v * v);
            end
            if (it.last)
            begin
                if (!it.in_mask || pix_energy == 0 || spec_energy == 0)
                begin
                    a.angle    = ANGLE_BITS'(181 << ANGLE_FRAC_BITS_DEF);
                    a.no_angle = 1'b1;
                end
                else
                begin
                    a.angle    = sam_angle(dot_sum, pix_energy, spec_energy);
                    a.no_angle = 1'b0;
                end
                angle_due = {angle_due, a};
                dot_sum    = '0;
                pix_energy = '0;
            end
        end
    endtask

    task automatic report(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at result %0d", what, got, want, n_out);
        errors++;
    endtask

    task automatic put(logic [1:0] act, int b, int v, bit mk, bit lst, bit ps = 0);
        band_req_t it;
        it.action  = act;
        it.band    = BAND_BITS'(b);
        it.value   = SAMPLE_BITS'(v);
        it.in_mask = mk;
        it.last    = lst;
        it.pause   = ps;
        pending = {pending, it};
        if (act != ACT_BAD)
            n_gen++;
        if (act == ACT_LOAD)
        begin
            g_val[b] = SAMPLE_BITS'(v);
            if (!(b inside {g_bands}))
                g_bands = {g_bands, b};
        end
        else if (act == ACT_CLEAR)
            g_bands.delete();
    endtask

    task automatic reload_spectrum();
        int k, b;
        put(ACT_CLEAR, $urandom_range(255), $urandom, $urandom_range(1), $urandom_range(1));
        k = $urandom_range(1, 12);
        repeat (k)
        begin
            b = $urandom_range(255);
            put(ACT_LOAD, b, $urandom_range(3) == 0 ? $urandom_range(63) : $urandom,
                $urandom_range(1), $urandom_range(1));
        end
    endtask

    task automatic random_pixel();
        int len, b, v, mode;
        len = $urandom_range(1, 8);
        mode = $urandom_range(3);
        for (int i = 0; i < len; i++)
        begin
            if (g_bands.size() > 0 && $urandom_range(99) < 85)
                b = g_bands[$urandom_range(g_bands.size() - 1)];
            else
                b = $urandom_range(255);
            case (mode)
                0:       v = $signed(g_val[b]);
                1:       v = -$signed(g_val[b]);
                2:       v = $urandom_range(200) - 100;
                default: v = $urandom;
            endcase
            put(ACT_PIXEL, b, v, $urandom_range(99) < 90, i == len - 1);
        end
    endtask

    always @(posedge clk)
    begin
        band_req_t nxt;
        bit        present;
        if (rst_n)
        begin
            if (smp.valid && smp.ready)
            begin
                sam_predict(cur);
                n_in++;
            end
            send_idle = n_in < total / 3 ? 29 : (n_in < 2 * total / 3 ? 73 : 0);
            recv_idle = n_in < total / 3 ? 73 : (n_in < 2 * total / 3 ? 29 : 0);
            if (!smp.valid || smp.ready)
            begin
                present = 1'b0;
                if (pending.size() > 0 && $urandom_range(99) >= send_idle &&
                    (!pending[0].pause || angle_due.size() == 0))
                begin
                    nxt     = pending.pop_front();
                    cur     = nxt;
                    present = 1'b1;
                    smp.action        <= nxt.action;
                    smp.band          <= nxt.band;
                    smp.sample_value  <= nxt.value;
                    smp.pixel_in_mask <= nxt.in_mask;
                    smp.last_sample   <= nxt.last;
                end
                smp.valid <= present;
            end
        end
    end

    always @(posedge clk)
    begin
        angle_t want;
        if (rst_n)
        begin
            if ((smp.valid && smp.ready) || (res.valid && res.ready))
                quiet = 0;
            else
                quiet++;
            if (res.valid && res.ready)
            begin
                n_out++;
                if (angle_due.size() == 0)
                begin
                    report("unexpected result angle", res.angle, 0);
                end
                else
                begin
                    want = angle_due.pop_front();
                    if (want.no_angle)
                        n_none++;
                    if (res.angle !== want.angle)
                        report("angle", res.angle, want.angle);
                    if (res.no_angle !== want.no_angle)
                        report("no_angle", res.no_angle, want.no_angle);
                end
            end
            res.ready <= $urandom_range(99) >= recv_idle;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("Watchdog expired with %0d results outstanding", angle_due.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        smp.valid = 1'b0;
        smp.action = ACT_LOAD;
        smp.band = '0;
        smp.sample_value = '0;
        smp.pixel_in_mask = 1'b0;
        smp.last_sample = 1'b0;
        res.ready = 1'b0;
        rst_n = 1'b0;
        errors = 0; n_in = 0; n_out = 0; n_none = 0; quiet = 0; n_gen = 0;
        spec_energy = '0; dot_sum = '0; pix_energy = '0;
        foreach (spec_mark[i])
            spec_mark[i] = 1'b0;
        foreach (g_val[i])
            g_val[i] = '0;

        put(ACT_LOAD, 0, -32768, 0, 1);
        put(ACT_LOAD, 255, 32767, 1, 0);
        put(ACT_PIXEL, 0, 32767, 1, 0);
        put(ACT_PIXEL, 255, -32768, 1, 1);
        put(ACT_PIXEL, 0, -32768, 1, 0);
        put(ACT_PIXEL, 255, 32767, 1, 1);
        put(ACT_PIXEL, 0, 100, 0, 1);
        put(ACT_PIXEL, 17, 5, 1, 1);
        put(ACT_LOAD, 0, 300, 0, 0);
        put(ACT_LOAD, 0, 0, 0, 0);
        put(ACT_LOAD, 128, 1000, 0, 0);
        put(ACT_PIXEL, 0, 77, 1, 0);
        put(ACT_PIXEL, 128, 0, 1, 1);
        put(ACT_PIXEL, 255, 1000, 1, 0);
        put(ACT_PIXEL, 128, 1000, 1, 1);
        put(ACT_BAD, 85, 21845, 1, 1);
        put(ACT_CLEAR, 170, -21846, 1, 1);
        put(ACT_PIXEL, 128, 500, 1, 1, 1);
        put(ACT_LOAD, 64, -1, 1, 1);
        put(ACT_PIXEL, 64, 1, 1, 1);

        reload_spectrum();
        total = RAND_ITEMS + n_gen;
        while (n_gen < total)
        begin
            case ($urandom_range(99)) inside
                [0:7]:   reload_spectrum();
                [8:11]:  put(ACT_LOAD, $urandom_range(255), $urandom, 0, 0);
                [12:13]: put(ACT_BAD, $urandom_range(255), $urandom, $urandom_range(1),
                             $urandom_range(1));
                default: random_pixel();
            endcase
            if ($urandom_range(49) == 0 && pending.size() > 0)
                pending[$].pause = 1'b1;
        end
        if (g_bands.size() == 0)
            put(ACT_LOAD, 3, 32767, 0, 0);
        for (int i = 0; i < 40; i++)
            put(ACT_PIXEL, g_bands[0], i % 2 ? 32767 : -32768, 1, i == 39);
        total = n_gen;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() > 0 || smp.valid)
            @(posedge clk);
        while (angle_due.size() > 0)
            @(posedge clk);
        repeat (250) @(posedge clk);

        $display("Run covered %0d requests and %0d results, %0d of them with no angle",
                 n_in, n_out, n_none);
        if (angle_due.size() != 0)
        begin
            $display("%0d expected results never arrived", angle_due.size());
            errors++;
        end
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire

// ===== spectral_angle_mapper.f =====
+incdir+rtl
rtl/sam_pkg.sv
rtl/sam_in_if.sv
rtl/sam_out_if.sv
rtl/sam_angle.sv
rtl/spectral_angle_mapper.sv
test/tb.sv
